>>> rtl/rpe_pkg.sv
// Package: shared types, widths and constants of the wheel pulse rpm estimator.
`timescale 1ns / 1ps
package rpe_pkg;

	localparam int TIME_W     = 32;
	localparam int PER_W      = 20;
	localparam int TMO_W      = 24;
	localparam int ALPHA_W    = 9;
	localparam int PPR_W      = 8;
	localparam int MAXRPM_W   = 10;
	localparam int RPM_W      = 18;
	localparam int SPEED_W    = 10;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;

	// shared divider and multiplier sizes
	localparam int DVD_W  = 34;
	localparam int DVS_W  = PER_W + PPR_W;
	localparam int MUL_A_W = PER_W;
	localparam int MUL_B_W = ALPHA_W;
	localparam int PROD_W = MUL_A_W + MUL_B_W;

	localparam int AVG_DEPTH = 5;

	localparam logic [RPM_W-1:0]   RPM_MAX = {RPM_W{1'b1}};
	localparam logic [DVD_W-1:0]   RPM_NUM = 34'd15360000000;
	localparam logic [ALPHA_W-1:0] ALPHA_ONE = 9'd256;
	localparam logic [PROD_W-1:0]  ROUND_HALF = 29'd128;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_ALPHA    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_PER  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_PER  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_PPR      = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_RPM  = 3'd6;

	// register reset values
	localparam logic [ALPHA_W-1:0]  RST_ALPHA    = 9'd26;
	localparam logic [PER_W-1:0]    RST_DEBOUNCE = 20'd2000;
	localparam logic [PER_W-1:0]    RST_MIN_PER  = 20'd5000;
	localparam logic [PER_W-1:0]    RST_MAX_PER  = 20'd1000000;
	localparam logic [TMO_W-1:0]    RST_TIMEOUT  = 24'd300000;
	localparam logic [PPR_W-1:0]    RST_PPR      = 8'd10;
	localparam logic [MAXRPM_W-1:0] RST_MAX_RPM  = 10'd600;

	// item commands
	localparam logic CMD_EDGE = 1'b0;
	localparam logic CMD_TICK = 1'b1;

	typedef struct packed {
		logic              command;
		logic [TIME_W-1:0] time_us;
	} item_t;

	typedef struct packed {
		logic [RPM_W-1:0]   rpm_q8;
		logic [SPEED_W-1:0] speed;
	} result_t;

endpackage

>>> rtl/wheel_pulse_rpm_estimator.sv
// Top level: wheel pulse rpm estimator with period latch, EMA and moving average.
`timescale 1ns / 1ps
// Sequence: an edge transaction is handled in S_IDLE. A tick without a fresh period
//   goes straight to S_FIN; a tick with a fresh period runs S_MUL, the first division,
//   S_EMA1, S_EMA2, S_PUSH, S_SUM, the second division and S_FIN, skipping S_EMA2 when
//   the first reading skips the blend. S_FIN waits until the output register is free.
// Throughput: one transaction at a time; the shared one-bit-per-cycle divider,
//   run twice per fresh period, sets the tick time.
// Reset: arst_n clears state, filter history and config registers to their defaults.
module wheel_pulse_rpm_estimator #(
	parameter int AVG_DEPTH = rpe_pkg::AVG_DEPTH
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              item_valid,
	output logic                              item_stall,
	input  rpe_pkg::item_t                    item,
	output logic                              result_valid,
	input  logic                              result_stall,
	output rpe_pkg::result_t                  result,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [rpe_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [rpe_pkg::CFG_DATA_W-1:0]    cfg_data
);

	localparam int IDX_W = (AVG_DEPTH > 1) ? $clog2(AVG_DEPTH) : 1;
	localparam int CNT_W = $clog2(AVG_DEPTH + 1);
	localparam int SUM_W = rpe_pkg::RPM_W + CNT_W;
	localparam int RPM_W = rpe_pkg::RPM_W;
	localparam int DVD_W = rpe_pkg::DVD_W;
	localparam int DVS_W = rpe_pkg::DVS_W;
	localparam int PROD_W = rpe_pkg::PROD_W;

	// sequencer codes
	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_MUL    = 4'd1;
	localparam logic [3:0] S_D1GO   = 4'd2;
	localparam logic [3:0] S_D1WAIT = 4'd3;
	localparam logic [3:0] S_EMA1   = 4'd4;
	localparam logic [3:0] S_EMA2   = 4'd5;
	localparam logic [3:0] S_PUSH   = 4'd6;
	localparam logic [3:0] S_SUM    = 4'd7;
	localparam logic [3:0] S_D2GO   = 4'd8;
	localparam logic [3:0] S_D2WAIT = 4'd9;
	localparam logic [3:0] S_FIN    = 4'd10;

	logic [3:0] state_q;

	// configuration registers
	logic [rpe_pkg::ALPHA_W-1:0]  alpha_q;
	logic [rpe_pkg::PER_W-1:0]    debounce_q;
	logic [rpe_pkg::PER_W-1:0]    min_per_q;
	logic [rpe_pkg::PER_W-1:0]    max_per_q;
	logic [rpe_pkg::TMO_W-1:0]    timeout_q;
	logic [rpe_pkg::PPR_W-1:0]    ppr_q;
	logic [rpe_pkg::MAXRPM_W-1:0] max_rpm_q;

	// tracker state
	logic [rpe_pkg::TIME_W-1:0] last_edge_q;
	logic [rpe_pkg::TIME_W-1:0] now_q;
	logic [rpe_pkg::PER_W-1:0]  period_q;
	logic                       pending_q;
	logic [RPM_W-1:0]           rpm_q;
	logic [RPM_W-1:0]           val_q;
	logic [PROD_W-1:0]          acc_q;
	logic [RPM_W-1:0]           hist_q [AVG_DEPTH];
	logic [IDX_W-1:0]           slot_q;
	logic                       full_q;
	logic [IDX_W-1:0]           idx_q;
	logic [CNT_W-1:0]           cnt_q;
	logic [SUM_W-1:0]           sum_q;
	logic [DVS_W-1:0]           dvs_q;

	logic                       out_valid_q;
	rpe_pkg::result_t           out_q;

	// combinational helpers
	logic                        accept;
	logic                        out_free;
	logic [rpe_pkg::TIME_W-1:0]  edge_gap;
	logic [rpe_pkg::TIME_W-1:0]  tick_gap;
	logic [rpe_pkg::ALPHA_W-1:0] alpha_eff;
	logic [rpe_pkg::MUL_A_W-1:0] mul_a;
	logic [rpe_pkg::MUL_B_W-1:0] mul_b;
	logic [PROD_W-1:0]           prod;
	logic [PROD_W-1:0]           ema_sum;
	logic [RPM_W-1:0]            inst_sat;
	logic [IDX_W-1:0]            slot_nx;
	logic                        full_nx;
	logic                        div_start;
	logic                        div_done;
	logic [DVD_W-1:0]            div_dvd;
	logic [DVS_W-1:0]            div_dvs;
	logic [DVD_W-1:0]            div_quo;
	logic [RPM_W-1:0]            rpm_tmo;
	logic [RPM_W-1:0]            rpm_fin;
	logic                        timed_out;

	assign cfg_ready  = 1'b1;
	assign item_stall = (state_q != S_IDLE);
	assign accept     = item_valid && !item_stall;
	assign out_free   = !out_valid_q || !result_stall;

	always_comb begin
		edge_gap  = item.time_us - last_edge_q;
		tick_gap  = now_q - last_edge_q;
		alpha_eff = (alpha_q > rpe_pkg::ALPHA_ONE) ? rpe_pkg::ALPHA_ONE : alpha_q;
	end

	// shared multiplier: period * pulses, then both EMA terms
	always_comb begin
		case (state_q)
			S_MUL: begin
				mul_a = period_q;
				mul_b = rpe_pkg::MUL_B_W'(ppr_q);
			end
			S_EMA1: begin
				mul_a = rpe_pkg::MUL_A_W'(val_q);
				mul_b = alpha_eff;
			end
			S_EMA2: begin
				mul_a = rpe_pkg::MUL_A_W'(rpm_q);
				mul_b = rpe_pkg::ALPHA_ONE - alpha_eff;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
		prod    = PROD_W'(mul_a) * PROD_W'(mul_b);
		ema_sum = acc_q + prod;
	end

	// saturate the instant rpm at the field maximum (also covers a zero divisor)
	assign inst_sat = (div_quo[DVD_W-1:RPM_W] != '0) ? rpe_pkg::RPM_MAX : div_quo[RPM_W-1:0];

	always_comb begin
		slot_nx = (slot_q == IDX_W'(AVG_DEPTH - 1)) ? '0 : slot_q + IDX_W'(1);
		full_nx = full_q || (slot_q == IDX_W'(AVG_DEPTH - 1));
	end

	// divider operands: rpm numerator first, rounded history sum second
	always_comb begin
		div_start = (state_q == S_D1GO) || (state_q == S_D2GO);
		if (state_q == S_D2GO) begin
			div_dvd = DVD_W'(sum_q) + DVD_W'(cnt_q >> 1);
			div_dvs = DVS_W'(cnt_q);
		end else begin
			div_dvd = rpe_pkg::RPM_NUM;
			div_dvs = dvs_q;
		end
	end

	rpe_div #(
		.DVD_W (DVD_W),
		.DVS_W (DVS_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dvd),
		.divisor  (div_dvs),
		.done     (div_done),
		.quotient (div_quo)
	);

	// timeout check first, then the upper bound
	always_comb begin
		timed_out = tick_gap > rpe_pkg::TIME_W'(timeout_q);
		rpm_tmo   = timed_out ? '0 : rpm_q;
		rpm_fin   = (rpm_tmo > {max_rpm_q, 8'd0}) ? '0 : rpm_tmo;
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_q    <= rpe_pkg::RST_ALPHA;
			debounce_q <= rpe_pkg::RST_DEBOUNCE;
			min_per_q  <= rpe_pkg::RST_MIN_PER;
			max_per_q  <= rpe_pkg::RST_MAX_PER;
			timeout_q  <= rpe_pkg::RST_TIMEOUT;
			ppr_q      <= rpe_pkg::RST_PPR;
			max_rpm_q  <= rpe_pkg::RST_MAX_RPM;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				rpe_pkg::REG_ALPHA:    alpha_q    <= cfg_data[rpe_pkg::ALPHA_W-1:0];
				rpe_pkg::REG_DEBOUNCE: debounce_q <= cfg_data[rpe_pkg::PER_W-1:0];
				rpe_pkg::REG_MIN_PER:  min_per_q  <= cfg_data[rpe_pkg::PER_W-1:0];
				rpe_pkg::REG_MAX_PER:  max_per_q  <= cfg_data[rpe_pkg::PER_W-1:0];
				rpe_pkg::REG_TIMEOUT:  timeout_q  <= cfg_data[rpe_pkg::TMO_W-1:0];
				rpe_pkg::REG_PPR:      ppr_q      <= cfg_data[rpe_pkg::PPR_W-1:0];
				rpe_pkg::REG_MAX_RPM:  max_rpm_q  <= cfg_data[rpe_pkg::MAXRPM_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// sequencer and tracker state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			last_edge_q <= '0;
			period_q    <= '0;
			pending_q   <= 1'b0;
			rpm_q       <= '0;
			slot_q      <= '0;
			full_q      <= 1'b0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < AVG_DEPTH; i++) begin
				hist_q[i] <= '0;
			end
		end else begin
			// drop the result once the far side takes it; a new one loads in S_FIN
			if (out_valid_q && !result_stall && state_q != S_FIN) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (item.command == rpe_pkg::CMD_EDGE) begin
							// ignore bounces; latch gaps inside the period window
							if (edge_gap >= rpe_pkg::TIME_W'(debounce_q)) begin
								if (edge_gap >= rpe_pkg::TIME_W'(min_per_q) &&
								    edge_gap <= rpe_pkg::TIME_W'(max_per_q)) begin
									period_q  <= edge_gap[rpe_pkg::PER_W-1:0];
									pending_q <= 1'b1;
								end
								last_edge_q <= item.time_us;
							end
						end else begin
							pending_q <= 1'b0;
							if (pending_q && period_q != '0) begin
								state_q <= S_MUL;
							end else begin
								state_q <= S_FIN;
							end
						end
					end
				end
				S_MUL:    state_q <= S_D1GO;
				S_D1GO:   state_q <= S_D1WAIT;
				S_D1WAIT: begin
					if (div_done) begin
						state_q <= S_EMA1;
					end
				end
				S_EMA1: begin
					// first reading after a stop is taken as is
					if (rpm_q == '0) begin
						state_q <= S_PUSH;
					end else begin
						state_q <= S_EMA2;
					end
				end
				S_EMA2:   state_q <= S_PUSH;
				S_PUSH: begin
					hist_q[slot_q] <= val_q;
					slot_q         <= slot_nx;
					full_q         <= full_nx;
					state_q        <= S_SUM;
				end
				S_SUM: begin
					if (CNT_W'(idx_q) + CNT_W'(1) == cnt_q) begin
						state_q <= S_D2GO;
					end
				end
				S_D2GO:   state_q <= S_D2WAIT;
				S_D2WAIT: begin
					if (div_done) begin
						rpm_q   <= div_quo[RPM_W-1:0];
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					// hold until the output register is free
					if (out_free) begin
						rpm_q       <= rpm_fin;
						if (timed_out) begin
							slot_q <= '0;
							full_q <= 1'b0;
						end
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					now_q <= item.time_us;
				end
			end
			S_MUL: dvs_q <= prod[DVS_W-1:0];
			S_D1WAIT: begin
				if (div_done) begin
					val_q <= inst_sat;
				end
			end
			S_EMA1: acc_q <= prod + rpe_pkg::ROUND_HALF;
			S_EMA2: val_q <= ema_sum[RPM_W+7:8];
			S_PUSH: begin
				cnt_q <= full_nx ? CNT_W'(AVG_DEPTH) : CNT_W'(slot_nx);
				idx_q <= '0;
				sum_q <= '0;
			end
			S_SUM: begin
				sum_q <= sum_q + SUM_W'(hist_q[idx_q]);
				idx_q <= idx_q + IDX_W'(1);
			end
			S_FIN: begin
				if (out_free) begin
					out_q.rpm_q8 <= rpm_fin;
					out_q.speed  <= rpm_fin[RPM_W-1:8];
				end
			end
			default: begin
			end
		endcase
	end

	assign result_valid = out_valid_q;
	assign result       = out_q;

endmodule

>>> rtl/rpe_div.sv
// Module: restoring divider, one quotient bit per cycle, shared by both divisions.
`timescale 1ns / 1ps
module rpe_div #(
	parameter int DVD_W = rpe_pkg::DVD_W,
	parameter int DVS_W = rpe_pkg::DVS_W
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DVD_W-1:0] dividend,
	input  logic [DVS_W-1:0] divisor,
	output logic             done,
	output logic [DVD_W-1:0] quotient
);

	localparam int CNT_W = $clog2(DVD_W + 1);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DVS_W-1:0] rem_q;
	logic [DVS_W-1:0] dvs_q;
	logic [DVD_W-1:0] quo_q;

	logic [DVS_W:0]   trial;
	logic             ge;
	logic [DVS_W:0]   diff;

	always_comb begin
		trial = {rem_q, quo_q[DVD_W-1]};
		ge    = trial >= {1'b0, dvs_q};
		diff  = trial - {1'b0, dvs_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(DVD_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// shift dividend bits out the top, quotient bits in the bottom
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dvs_q <= divisor;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
			quo_q <= {quo_q[DVD_W-2:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

>>> rtl/rpe_chk.sv
// Checker: port-level assertions for the wheel pulse rpm estimator, with its bind.
`timescale 1ns / 1ps
module rpe_chk (
	input logic             clk,
	input logic             arst_n,
	input logic             item_valid,
	input logic             item_stall,
	input rpe_pkg::item_t   item,
	input logic             result_valid,
	input logic             result_stall,
	input rpe_pkg::result_t result
);

	// speed is always the integer part of the filtered rpm
	a_speed_matches: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> result.speed == result.rpm_q8[17:8])
		else $error("speed does not match rpm_q8");

	// an accepted tick transaction moves the sequencer out of S_IDLE and raises item_stall
	a_tick_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(item_valid && !item_stall && item.command == rpe_pkg::CMD_TICK) |=> item_stall)
		else $error("block ready right after a tick transaction");

	// a stalled result holds
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result_stall) |=> (result_valid && $stable(result)))
		else $error("stalled result changed or dropped");

	// an edge transaction never produces a result
	a_edge_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(item_valid && !item_stall && item.command == rpe_pkg::CMD_EDGE && !result_valid)
		|=> !result_valid)
		else $error("result after an edge transaction");

endmodule

bind wheel_pulse_rpm_estimator rpe_chk u_rpe_chk (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_valid   (item_valid),
	.item_stall   (item_stall),
	.item         (item),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.result       (result)
);
